// ----- sv/srs_pkg.sv -----
// Shared types, constants and helper functions for the supply rail sequencer.
`default_nettype none

package srs_pkg;

    // Number of rails sequenced: 0 core, 1 DRAM, 2 1.8 V, 3 3.3 V, 4 TX.
    localparam int NUM_RAILS = 5;

    // Field widths.
    localparam int RAIL_W   = 3;
    localparam int RETRY_W  = 4;
    localparam int MV_W     = 13;
    localparam int ERR_W    = 3;
    localparam int MASK_W   = 5;
    localparam int CFG_IDX_W = 3;

    // Last rail of the power-up order, where power-down starts.
    localparam logic [RAIL_W-1:0] LAST_RAIL = RAIL_W'(NUM_RAILS - 1);

    // Reset value of the retry limit.
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(10);

    // Largest error code.
    localparam logic [ERR_W-1:0] ERR_SATURATED = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_MV        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIPH_LOW_MV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIPH_HIGH_MV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_MV          = 3'd4;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_POWER_UP   = 2'd0,
        OP_POWER_DOWN = 2'd1,
        OP_OUTCOME    = 2'd2,
        OP_CLEAR_ERR  = 2'd3
    } opcode_t;

    // Sequence phase, reported as sequence_status.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RUN   = 2'd1,
        PH_DONE  = 2'd2,
        PH_ABORT = 2'd3
    } phase_t;

    // Input item.
    typedef struct packed {
        logic [1:0] opcode;
        logic       attempt_ok;
    } item_t;

    // Result item.
    typedef struct packed {
        logic                attempt_request;
        logic [RAIL_W-1:0]   rail_index;
        logic                rail_enable;
        logic [RETRY_W-1:0]  attempt_number;
        logic                switch_now;
        logic [MV_W-1:0]     setpoint_mv;
        logic                status_led;
        logic                fpga_held_reset;
        logic [1:0]          sequence_status;
        logic [ERR_W-1:0]    error_code;
        logic [MASK_W-1:0]   rails_on_mask;
        logic                system_on;
    } result_t;

    // Configuration register bank as seen by the sequencing logic.
    typedef struct packed {
        logic [RETRY_W-1:0] retry_limit;
        logic [MV_W-1:0]    dram_voltage_mv;
        logic [MV_W-1:0]    periph_low_voltage_mv;
        logic [MV_W-1:0]    periph_high_voltage_mv;
        logic [MV_W-1:0]    tx_voltage_mv;
    } cfg_regs_t;

    // Setpoint programmed for a rail on power-up; the core rail has none.
    function automatic logic [MV_W-1:0] rail_setpoint(cfg_regs_t cfg,
                                                      logic [RAIL_W-1:0] rail);
        logic [MV_W-1:0] mv;
        mv = '0;
        unique case (rail)
            3'd1:    mv = cfg.dram_voltage_mv;
            3'd2:    mv = cfg.periph_low_voltage_mv;
            3'd3:    mv = cfg.periph_high_voltage_mv;
            3'd4:    mv = cfg.tx_voltage_mv;
            default: mv = '0;
        endcase
        return mv;
    endfunction

endpackage

`default_nettype wire

// ----- sv/srs_cfg.sv -----
// Configuration register bank of the supply rail sequencer.
`default_nettype none

module srs_cfg
    import srs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MV_W-1:0]      cfg_data,
    output cfg_regs_t                 regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;
    logic      write_en;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid && cfg_ready;

    // Decode the register index; unknown indexes are dropped.
    always_comb
    begin
        regs_next = regs_reg;
        if (write_en)
        begin
            unique case (cfg_index)
                CFG_RETRY_LIMIT:    regs_next.retry_limit = cfg_data[RETRY_W-1:0];
                CFG_DRAM_MV:        regs_next.dram_voltage_mv = cfg_data;
                CFG_PERIPH_LOW_MV:  regs_next.periph_low_voltage_mv = cfg_data;
                CFG_PERIPH_HIGH_MV: regs_next.periph_high_voltage_mv = cfg_data;
                CFG_TX_MV:          regs_next.tx_voltage_mv = cfg_data;
                default:            regs_next = regs_reg;
            endcase
        end
    end

    // Register bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.retry_limit            <= RETRY_LIMIT_RESET;
            regs_reg.dram_voltage_mv        <= '0;
            regs_reg.periph_low_voltage_mv  <= '0;
            regs_reg.periph_high_voltage_mv <= '0;
            regs_reg.tx_voltage_mv          <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

// ----- sv/srs_step.sv -----
// Sequencing state and the single-pass step logic that forms each result.
`default_nettype none

module srs_step
    import srs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire item_t     item,
    input  wire cfg_regs_t cfg,
    output result_t        result
);

    phase_t              phase_reg, phase_next;
    logic [RAIL_W-1:0]   pos_reg, pos_next;
    logic [RETRY_W-1:0]  retry_reg, retry_next;
    logic                led_reg, led_next;
    logic [MASK_W-1:0]   flags_reg, flags_next;
    logic                sys_up_reg, sys_up_next;
    logic [ERR_W-1:0]    err_reg, err_next;
    logic                hold_reg, hold_next;
    logic                up_reg, up_next;

    logic                request;
    logic                ok;
    logic [7:0]          pos_onehot;
    logic [MASK_W-1:0]   rail_bit;
    logic [RETRY_W-1:0]  limit;
    logic [RETRY_W:0]    retry_inc;
    logic [RAIL_W:0]     pos_inc;
    logic [ERR_W-1:0]    fail_code;
    opcode_t             op;

    assign op = opcode_t'(item.opcode);

    // Helpers for the outcome of the current attempt.
    always_comb
    begin
        ok         = item.attempt_ok || (!up_reg && pos_reg == '0);
        pos_onehot = 8'd1 << pos_reg;
        rail_bit   = pos_onehot[MASK_W-1:0];
        limit      = (cfg.retry_limit == '0) ? RETRY_W'(1) : cfg.retry_limit;
        retry_inc  = {1'b0, retry_reg} + (RETRY_W+1)'(1);
        pos_inc    = {1'b0, pos_reg} + (RAIL_W+1)'(1);
        fail_code  = (pos_inc > (RAIL_W+1)'(ERR_SATURATED)) ? ERR_SATURATED
                                                            : pos_inc[ERR_W-1:0];
    end

    // Next state for one accepted item.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        retry_next  = retry_reg;
        led_next    = led_reg;
        flags_next  = flags_reg;
        sys_up_next = sys_up_reg;
        err_next    = err_reg;
        hold_next   = hold_reg;
        up_next     = up_reg;
        request     = 1'b0;
        if (accept)
        begin
            unique case (op)
                OP_CLEAR_ERR:
                begin
                    err_next = '0;
                end
                OP_POWER_UP, OP_POWER_DOWN:
                begin
                    if (phase_reg != PH_RUN)
                    begin
                        up_next    = (op == OP_POWER_UP);
                        phase_next = PH_RUN;
                        retry_next = '0;
                        hold_next  = 1'b1;
                        pos_next   = (op == OP_POWER_UP) ? '0 : LAST_RAIL;
                        led_next   = (op == OP_POWER_UP);
                        request    = 1'b1;
                    end
                end
                OP_OUTCOME:
                begin
                    if (phase_reg == PH_RUN)
                    begin
                        if (ok)
                        begin
                            flags_next = up_reg ? (flags_reg | rail_bit)
                                                : (flags_reg & ~rail_bit);
                            if (up_reg && pos_inc < (RAIL_W+1)'(NUM_RAILS))
                            begin
                                pos_next   = pos_inc[RAIL_W-1:0];
                                retry_next = '0;
                                led_next   = ~led_reg;
                                request    = 1'b1;
                            end
                            else if (!up_reg && pos_reg != '0)
                            begin
                                pos_next   = pos_reg - RAIL_W'(1);
                                retry_next = '0;
                                led_next   = ~led_reg;
                                request    = 1'b1;
                            end
                            else
                            begin
                                phase_next  = PH_DONE;
                                led_next    = up_reg;
                                sys_up_next = up_reg;
                                if (up_reg)
                                begin
                                    hold_next = 1'b0;
                                end
                            end
                        end
                        else if (retry_inc >= {1'b0, limit})
                        begin
                            if (up_reg || err_reg == '0)
                            begin
                                err_next = fail_code;
                            end
                            phase_next = PH_ABORT;
                        end
                        else
                        begin
                            retry_next = retry_inc[RETRY_W-1:0];
                            request    = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result built from the state this item leaves behind.
    always_comb
    begin
        result.attempt_request = request;
        result.rail_index      = request ? pos_next : '0;
        result.rail_enable     = request && up_next;
        result.attempt_number  = request ? retry_next : '0;
        result.switch_now      = request && ((pos_next != '0) || (retry_next == '0));
        result.setpoint_mv     = (request && up_next) ? rail_setpoint(cfg, pos_next) : '0;
        result.status_led      = led_next;
        result.fpga_held_reset = hold_next;
        result.sequence_status = phase_next;
        result.error_code      = err_next;
        result.rails_on_mask   = flags_next;
        result.system_on       = sys_up_next;
    end

    // Sequencing state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            retry_reg  <= '0;
            led_reg    <= 1'b0;
            flags_reg  <= '0;
            sys_up_reg <= 1'b0;
            err_reg    <= '0;
            hold_reg   <= 1'b1;
            up_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            retry_reg  <= retry_next;
            led_reg    <= led_next;
            flags_reg  <= flags_next;
            sys_up_reg <= sys_up_next;
            err_reg    <= err_next;
            hold_reg   <= hold_next;
            up_reg     <= up_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/srs_outq.sv -----
// Two-entry result queue that parts the input side from the result side.
`default_nettype none

module srs_outq
    import srs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         not_full,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    // Queue occupancy and pointers.
    always_comb
    begin
        not_full     = (count_reg != 2'd2);
        result_valid = (count_reg != 2'd0);
        result       = slot_reg[rd_ptr_reg];
        pop          = result_valid && result_ready;
        wr_ptr_next  = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next   = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/supply_rail_sequencer.sv -----
// Top level of the supply rail sequencer: configuration, step logic and result queue.
//
// Every accepted item (start power-up, start power-down, attempt outcome or clear error)
// produces exactly one result item, written into a two-entry result queue at the edge
// that accepts it, and is offered once earlier results are taken. An item is taken in
// every cycle as long as the queue has a free entry; the queue depth of two sets how far
// the input may run ahead of a stalled result side. Configuration writes are taken at
// once and must only be issued while the sequencer is idle.
`default_nettype none

module supply_rail_sequencer
    import srs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MV_W-1:0]      cfg_data
);

    cfg_regs_t cfg;
    result_t   step_result;
    logic      accept;
    logic      not_full;

    assign item_ready = not_full;
    assign accept     = item_valid && item_ready;

    // Configuration registers.
    srs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    // Sequencing state and step logic.
    srs_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .result (step_result)
    );

    // Result queue.
    srs_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_data    (step_result),
        .not_full     (not_full),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // An accepted item always leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
    else $error("accepted item produced no result");

    // Attempt fields are zero when no attempt is requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.attempt_request) |->
        (result.rail_index == '0 && !result.rail_enable && result.attempt_number == '0
         && !result.switch_now && result.setpoint_mv == '0))
    else $error("attempt fields set without an attempt request");

    // FPGA reset is only released once the system is up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.fpga_held_reset) |-> result.system_on)
    else $error("FPGA reset released while system is not up");

endmodule

`default_nettype wire
